[src/swds_pkg.sv]
`default_nettype none

package swds_pkg;

   // Eight-step duty patterns, one byte per duty setting, step 0 in the low bit
   localparam logic [31:0] DUTY_PATTERN = 32'h7EE1_8180;

   localparam int FREQ_W   = 11;
   localparam int COUNT_W  = 13;
   localparam int POS_W    = 3;
   localparam int DUTY_W   = 2;

   // Extra cycles from trigger to the first step
   localparam logic [COUNT_W-1:0] TRIGGER_DELAY = COUNT_W'(4);
   localparam logic [12:0] PERIOD_BASE = 13'd2048;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_DUTY       = 3'd1,
      OP_FREQ_LOW   = 3'd2,
      OP_FREQ_HIGH  = 3'd3,
      OP_RESET      = 3'd4
   } op_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  frequency;
      logic [DUTY_W-1:0]  duty_select;
      logic [POS_W-1:0]   wave_position;
      logic               wave_level;
      logic [COUNT_W-1:0] step_countdown;
      logic               is_running;
      logic               cycle_parity;
   } seq_state_type;

   // Step period: (2048 - frequency) * 2, always in 2..4096
   function automatic logic [COUNT_W-1:0] step_period(input logic [FREQ_W-1:0] freq);
      logic [12:0] diff;
      diff = PERIOD_BASE - {2'b00, freq};
      return {diff[11:0], 1'b0};
   endfunction

   function automatic logic pattern_bit(input logic [DUTY_W-1:0] duty,
                                        input logic [POS_W-1:0] pos);
      return DUTY_PATTERN[{duty, pos}];
   endfunction

endpackage

`default_nettype wire

[src/swds_step.sv]
`default_nettype none

module swds_step
   import swds_pkg::*;
(
   input  seq_state_type cur,
   input  logic [2:0]    op,
   input  logic [7:0]    value,
   output seq_state_type nxt
);

   logic [COUNT_W-1:0] count_dec;
   logic [POS_W-1:0]   pos_inc;
   logic [FREQ_W-1:0]  freq_high;

   always_comb begin
      count_dec = (cur.step_countdown != '0) ? cur.step_countdown - COUNT_W'(1)
                                              : cur.step_countdown;
      pos_inc   = cur.wave_position + POS_W'(1);
      freq_high = {value[2:0], cur.frequency[7:0]};
   end

   always_comb begin
      nxt = cur;
      unique case (op_type'(op))
         OP_TICK: begin
            nxt.cycle_parity = ~cur.cycle_parity;
            if (cur.is_running) begin
               nxt.step_countdown = count_dec;
               if (count_dec == '0) begin
                  // advance one step and reload the period
                  nxt.wave_position  = pos_inc;
                  nxt.wave_level     = pattern_bit(cur.duty_select, pos_inc);
                  nxt.step_countdown = step_period(cur.frequency);
               end
            end
         end
         OP_DUTY: begin
            nxt.duty_select = value[7:6];
         end
         OP_FREQ_LOW: begin
            nxt.frequency = {cur.frequency[10:8], value};
         end
         OP_FREQ_HIGH: begin
            nxt.frequency = freq_high;
            if (value[7]) begin
               // align the first step to the even cycle at or before now
               nxt.step_countdown = step_period(freq_high) + TRIGGER_DELAY
                                    - COUNT_W'(cur.cycle_parity);
               nxt.is_running     = 1'b1;
            end
         end
         OP_RESET: begin
            nxt.wave_position  = '0;
            nxt.wave_level     = 1'b0;
            nxt.step_countdown = '0;
            nxt.is_running     = 1'b0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/square_wave_duty_sequencer_core.sv]
`default_nettype none
// Each accepted request leaves its result registered on the rsp_ port in the next cycle.
// Throughput: one request per cycle while no result is stalled; the sequencer state is
//   the result register; a new request is taken in the same cycle as the pending result.
// Reset (synchronous, active high) clears frequency, duty, position, level,
//   countdown, running and parity, and drops any pending result.

module square_wave_duty_sequencer_core
   import swds_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_op,
   input  wire logic [7:0] req_value,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_level,
   output logic [2:0]      rsp_position,
   output logic            rsp_running
);

   seq_state_type state_ff;
   seq_state_type state_in;
   seq_state_type step_next;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          req_accept;
   logic          rsp_taken;

   // All per-request work: one pass of next-state logic
   swds_step u_step (
      .cur   (state_ff),
      .op    (req_op),
      .value (req_value),
      .nxt   (step_next)
   );

   // Hold the request while a result waits and the consumer stalls
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_taken  = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      state_in     = req_accept ? step_next : state_ff;
      rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_taken);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The state only moves on an accepted request, so it is the result as shown
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = state_ff.wave_level;
   assign rsp_position = state_ff.wave_position;
   assign rsp_running  = state_ff.is_running;

   a_running_countdown: assert property (@(posedge clock) disable iff (reset)
      state_ff.is_running |-> state_ff.step_countdown != '0)
      else $error("sequencer running with a zero countdown");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with no pending result");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_op == OP_TICK && !state_ff.is_running
      |=> $stable(state_ff.wave_position) && !state_ff.is_running)
      else $error("stopped sequencer moved on a tick");

   a_tick_parity: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_op == OP_TICK
      |=> state_ff.cycle_parity != $past(state_ff.cycle_parity))
      else $error("tick did not toggle cycle parity");

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swds_pkg::*;

   // Spare opcodes the block must ignore while still returning its status
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int         TRIGGER_BIT = 7;
   localparam int         PHASES = 4;
   localparam int         REQUESTS_PER_PHASE = 460;
   // Margin to let pass after the last result before the verdict
   localparam int         DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] value;
   } seq_request_type;

   typedef struct packed {
      logic       level;
      logic [2:0] position;
      logic       running;
   } wave_status_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_op = '0;
   logic [7:0] req_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_level;
   logic [2:0] rsp_position;
   logic       rsp_running;

   // Requests waiting to be driven, and wave status the block owes us
   seq_request_type pending_requests[$];
   wave_status_type owed_status[$];
   seq_request_type next_request;
   wave_status_type oldest_status;

   int error_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   // Shadow of the sequencer state, advanced once per accepted request
   logic [FREQ_W-1:0]  shadow_freq;
   logic [DUTY_W-1:0]  shadow_duty;
   logic [POS_W-1:0]   shadow_pos;
   logic               shadow_level;
   logic [COUNT_W-1:0] shadow_countdown;
   logic               shadow_running;
   logic               shadow_parity;

   square_wave_duty_sequencer_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_level    (rsp_level),
      .rsp_position (rsp_position),
      .rsp_running  (rsp_running)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Step period in cycles: twice the distance of the frequency from 2048
   function automatic logic [COUNT_W-1:0] wave_period(input logic [FREQ_W-1:0] freq);
      logic [11:0] span;
      span = 12'd2048 - {1'b0, freq};
      return {span, 1'b0};
   endfunction

   function automatic void clear_shadow();
      shadow_freq      = '0;
      shadow_duty      = '0;
      shadow_pos       = '0;
      shadow_level     = 1'b0;
      shadow_countdown = '0;
      shadow_running   = 1'b0;
      shadow_parity    = 1'b0;
   endfunction

   // Apply one request to the shadow state and queue the status it leaves behind
   function automatic void advance_sequencer(input logic [2:0] op, input logic [7:0] value);
      wave_status_type status;
      case (op)
         OP_TICK: begin
            shadow_parity = ~shadow_parity;
            if (shadow_running) begin
               if (shadow_countdown != '0)
                  shadow_countdown = shadow_countdown - 1'b1;
               // Step the pattern when the countdown runs out, then reload
               if (shadow_countdown == '0) begin
                  shadow_pos       = shadow_pos + 1'b1;
                  shadow_level     = DUTY_PATTERN[{shadow_duty, shadow_pos}];
                  shadow_countdown = wave_period(shadow_freq);
               end
            end
         end
         // Duty change leaves the current level alone until the next step
         OP_DUTY: shadow_duty = value[7:6];
         // Frequency writes keep the pending countdown unless they trigger
         OP_FREQ_LOW: shadow_freq[7:0] = value;
         OP_FREQ_HIGH: begin
            shadow_freq[10:8] = value[2:0];
            // Trigger: first step lands a period plus TRIGGER_DELAY after the even cycle
            if (value[TRIGGER_BIT]) begin
               shadow_countdown = wave_period(shadow_freq) + TRIGGER_DELAY
                                  - {{(COUNT_W-1){1'b0}}, shadow_parity};
               shadow_running = 1'b1;
            end
         end
         // Stop and clear position and level; frequency, duty and parity survive
         OP_RESET: begin
            shadow_pos       = '0;
            shadow_level     = 1'b0;
            shadow_countdown = '0;
            shadow_running   = 1'b0;
         end
         default: ;
      endcase
      status.level    = shadow_level;
      status.position = shadow_pos;
      status.running  = shadow_running;
      owed_status.push_back(status);
   endfunction

   task automatic push_request(input logic [2:0] op, input logic [7:0] value);
      seq_request_type item;
      item.op    = op;
      item.value = value;
      pending_requests.push_back(item);
   endtask

   // Hit the corners: idle ticks, all duties, frequency extremes, trigger on
   // both parities, retrigger, reset item and the spare opcodes
   task automatic queue_corner_cases();
      push_request(OP_TICK, 8'h00);
      push_request(OP_TICK, 8'hFF);
      push_request(OP_DUTY, 8'hC0);
      push_request(OP_FREQ_LOW, 8'hFF);
      push_request(OP_FREQ_HIGH, 8'h07);
      push_request(OP_TICK, 8'h00);
      push_request(OP_FREQ_HIGH, 8'h87);
      repeat (5) push_request(OP_TICK, 8'h00);
      push_request(OP_DUTY, 8'h3F);
      push_request(OP_TICK, 8'h00);
      push_request(OP_FREQ_LOW, 8'h00);
      push_request(OP_TICK, 8'h00);
      push_request(OP_FREQ_HIGH, 8'hFF);
      push_request(OP_TICK, 8'h00);
      push_request(OP_RESET, 8'h00);
      push_request(OP_SPARE_LO, 8'hFF);
      push_request(OP_SPARE_HI, 8'h00);
      push_request(OP_FREQ_HIGH, 8'h80);
      push_request(OP_TICK, 8'h00);
      push_request(OP_DUTY, 8'h40);
      push_request(OP_DUTY, 8'h80);
      push_request(OP_RESET, 8'hFF);
   endtask

   // Mostly well-formed runs: set up a fast tone, trigger it and tick through
   // many steps, with writes sprinkled in; the rest is bare ticks and noise
   task automatic queue_traffic(inout int added);
      int kind;
      int pick;
      int fbits;
      logic [7:0] low;
      logic [2:0] op;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         if ($urandom_range(0, 2) == 0) begin
            push_request(OP_DUTY, 8'($urandom));
            added++;
         end
         low = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'hE0, 8'hFF));
         fbits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 7;
         push_request(OP_FREQ_LOW, low);
         push_request(OP_FREQ_HIGH, {1'b1, 4'($urandom), 3'(fbits)});
         added += 2;
         repeat ($urandom_range(4, 60)) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               push_request(OP_FREQ_LOW, 8'($urandom_range(8'hE0, 8'hFF)));
            else if (pick < 10)
               push_request(OP_DUTY, 8'($urandom));
            else if (pick < 13)
               push_request(OP_FREQ_HIGH, {1'($urandom), 4'($urandom), 3'd7});
            else
               push_request(OP_TICK, 8'($urandom));
            added++;
         end
         if ($urandom_range(0, 11) == 0) begin
            push_request(OP_RESET, 8'($urandom));
            added++;
         end
      end else if (kind < 85) begin
         repeat ($urandom_range(1, 20)) begin
            push_request(OP_TICK, 8'($urandom));
            added++;
         end
      end else begin
         repeat ($urandom_range(1, 4)) begin
            op = 3'($urandom_range(0, OP_SPARE_HI));
            push_request(op, 8'($urandom));
            if (op <= OP_RESET)
               added++;
         end
      end
   endtask

   // Driver: hold a stalled request, otherwise launch the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_shadow();
         owed_status.delete();
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            advance_sequencer(req_op, req_value);
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_request = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_op    <= next_request.op;
            req_value <= next_request.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each taken status against the oldest one owed, then
   // pick the stall for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_status.size() == 0) begin
               $error("unexpected status: level %0d position %0d running %0d",
                      rsp_level, rsp_position, rsp_running);
               error_count++;
            end else begin
               oldest_status = owed_status.pop_front();
               if (rsp_level !== oldest_status.level) begin
                  $error("level: expected %0d, got %0d", oldest_status.level, rsp_level);
                  error_count++;
               end
               if (rsp_position !== oldest_status.position) begin
                  $error("position: expected %0d, got %0d",
                         oldest_status.position, rsp_position);
                  error_count++;
               end
               if (rsp_running !== oldest_status.running) begin
                  $error("running: expected %0d, got %0d",
                         oldest_status.running, rsp_running);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Sequence the run: reset once, then one phase per idling style, draining
   // fully between phases
   initial begin
      int phase;
      int added;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         if (phase == 0)
            queue_corner_cases();
         added = 0;
         while (added < REQUESTS_PER_PHASE)
            queue_traffic(added);
         while (pending_requests.size() != 0 || req_valid || owed_status.size() != 0)
            @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5ms;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
